FILE: hw/rtl/jsu_pkg.sv
// jsu_pkg: shared types, codes and constants of the json string unescaper
// no dependencies
`default_nettype none

package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 4;
  localparam int JSU_CP_W        = 21;

  // characters of interest
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // surrogate ranges and utf-8 limits
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [JSU_CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [JSU_CP_W-1:0] UTF8_MAX1 = 21'h0007F;
  localparam logic [JSU_CP_W-1:0] UTF8_MAX2 = 21'h007FF;
  localparam logic [JSU_CP_W-1:0] UTF8_MAX3 = 21'h0FFFF;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_END     = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_BADESC  = 3'd3,
    ST_CTRL    = 3'd4,
    ST_BADHEX  = 3'd5,
    ST_BADSUR  = 3'd6
  } jsu_status_t;

  typedef enum logic [2:0] {
    PH_TEXT    = 3'd0,
    PH_ESC     = 3'd1,
    PH_HEX_HI  = 3'd2,
    PH_WANT_BS = 3'd3,
    PH_WANT_U  = 3'd4,
    PH_HEX_LO  = 3'd5
  } jsu_phase_t;

  // one queued command: a raw byte, a code point to encode, or a status
  typedef struct packed {
    jsu_status_t         status;
    logic                is_cp;
    logic [JSU_CP_W-1:0] value;
  } jsu_cmd_t;

  // hex digit value, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jsu_if.sv
// jsu_in_if / jsu_out_if: valid-ready channels of the unescaper
// no dependencies
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jsu_front.sv
// jsu_front: escape parser, takes one byte a cycle while the queue has room and queues one command or none
// depends on jsu_pkg and jsu_in_if
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      push_valid,
  output jsu_cmd_t  push_cmd
);

  jsu_phase_t  phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [15:0] lo_r, lo_nxt;

  logic        accept;
  logic [4:0]  hv;
  logic [15:0] unit_new;
  logic        fail_v;
  jsu_status_t fail_st;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign hv          = hex_value(in_ch.in_byte);
  assign unit_new    = (phase_r == PH_HEX_HI) ? {hi_r[11:0], hv[3:0]} : {lo_r[11:0], hv[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      cnt_r   <= '0;
      hi_r    <= '0;
      lo_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    push_valid = 1'b0;
    push_cmd   = '{status: ST_BYTE, is_cp: 1'b0, value: '0};
    fail_v     = 1'b0;
    fail_st    = ST_BYTE;
    if (accept) begin
      unique case (phase_r)
        PH_ESC: begin
          phase_nxt = PH_TEXT;
          unique case (in_ch.in_byte) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(in_ch.in_byte);
            end
            CH_B: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(BYTE_BS);
            end
            CH_F: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(BYTE_FF);
            end
            CH_N: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(BYTE_LF);
            end
            CH_R: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(BYTE_CR);
            end
            CH_T: begin
              push_valid     = 1'b1;
              push_cmd.value = JSU_CP_W'(BYTE_TAB);
            end
            CH_U: begin
              phase_nxt = PH_HEX_HI;
              cnt_nxt   = '0;
              hi_nxt    = '0;
            end
            default: begin
              fail_v  = 1'b1;
              fail_st = ST_BADESC;
            end
          endcase
        end
        PH_HEX_HI, PH_HEX_LO: begin
          if (hv[4]) begin
            fail_v  = 1'b1;
            fail_st = ST_BADHEX;
          end else begin
            if (phase_r == PH_HEX_HI) hi_nxt = unit_new;
            else lo_nxt = unit_new;
            if (cnt_r != 2'd3) begin
              cnt_nxt = cnt_r + 2'd1;
            end else begin
              cnt_nxt = '0;
              if (phase_r == PH_HEX_HI) begin
                if (unit_new >= HI_SUR_MIN && unit_new <= HI_SUR_MAX) begin
                  phase_nxt = PH_WANT_BS;
                end else begin
                  phase_nxt      = PH_TEXT;
                  push_valid     = 1'b1;
                  push_cmd.is_cp = 1'b1;
                  push_cmd.value = JSU_CP_W'(unit_new);
                end
              end else if (unit_new < LO_SUR_MIN || unit_new > LO_SUR_MAX) begin
                fail_v  = 1'b1;
                fail_st = ST_BADSUR;
              end else begin
                // offsets below the surrogate bases are the low ten bits
                phase_nxt      = PH_TEXT;
                push_valid     = 1'b1;
                push_cmd.is_cp = 1'b1;
                push_cmd.value = {1'b0, hi_r[9:0], unit_new[9:0]} + SUPP_BASE;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (in_ch.in_byte != CH_BSLASH) begin
            fail_v  = 1'b1;
            fail_st = ST_BADSUR;
          end else begin
            phase_nxt = PH_WANT_U;
          end
        end
        PH_WANT_U: begin
          if (in_ch.in_byte != CH_U) begin
            fail_v  = 1'b1;
            fail_st = ST_BADSUR;
          end else begin
            phase_nxt = PH_HEX_LO;
            cnt_nxt   = '0;
            lo_nxt    = '0;
          end
        end
        default: begin
          // normal text, unused codes too
          phase_nxt = PH_TEXT;
          if (in_ch.in_byte == CH_QUOTE) begin
            fail_v  = 1'b1;
            fail_st = ST_END;
          end else if (in_ch.in_byte == CH_NUL) begin
            fail_v  = 1'b1;
            fail_st = ST_NOQUOTE;
          end else if (in_ch.in_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else if (in_ch.in_byte < CTRL_LIMIT) begin
            fail_v  = 1'b1;
            fail_st = ST_CTRL;
          end else begin
            push_valid     = 1'b1;
            push_cmd.value = JSU_CP_W'(in_ch.in_byte);
          end
        end
      endcase
      if (fail_v) begin
        phase_nxt  = PH_TEXT;
        cnt_nxt    = '0;
        hi_nxt     = '0;
        lo_nxt     = '0;
        push_valid = 1'b1;
        push_cmd   = '{status: fail_st, is_cp: 1'b0, value: '0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_queue.sv
// jsu_queue: small command fifo between parser and encoder
// depends on jsu_pkg
`default_nettype none

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = JSU_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire jsu_cmd_t  push_cmd,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output jsu_cmd_t       head_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_cmd_t         entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_back.sv
// jsu_back: utf-8 encoder, sends one result byte a cycle from the queue head while the output is taken
// depends on jsu_pkg and jsu_out_if
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     head_valid,
  input  wire jsu_cmd_t head_cmd,
  output logic          pop,
  jsu_out_if.source     out_ch
);

  logic [1:0]  idx_r;
  logic        valid_r;
  logic [7:0]  byte_r;
  jsu_status_t status_r;
  logic        last_r;

  logic [1:0]          last_idx;
  logic [7:0]          byte_sel;
  logic [JSU_CP_W-1:0] v;
  logic                load;
  logic                is_last;

  assign v       = head_cmd.value;
  assign load    = head_valid && (!valid_r || out_ch.ready);
  assign is_last = (idx_r == last_idx);
  assign pop     = load && is_last;

  always_comb begin
    last_idx = 2'd0;
    byte_sel = v[7:0];
    if (head_cmd.is_cp) begin
      if (v <= UTF8_MAX1) begin
        last_idx = 2'd0;
        byte_sel = v[7:0];
      end else if (v <= UTF8_MAX2) begin
        last_idx = 2'd1;
        case (idx_r)
          2'd0:    byte_sel = {3'b110, v[10:6]};
          default: byte_sel = {2'b10, v[5:0]};
        endcase
      end else if (v <= UTF8_MAX3) begin
        last_idx = 2'd2;
        case (idx_r)
          2'd0:    byte_sel = {4'b1110, v[15:12]};
          2'd1:    byte_sel = {2'b10, v[11:6]};
          default: byte_sel = {2'b10, v[5:0]};
        endcase
      end else begin
        last_idx = 2'd3;
        case (idx_r)
          2'd0:    byte_sel = {5'b11110, v[20:18]};
          2'd1:    byte_sel = {2'b10, v[17:12]};
          2'd2:    byte_sel = {2'b10, v[11:6]};
          default: byte_sel = {2'b10, v[5:0]};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_sel;
      status_r <= head_cmd.status;
      last_r   <= is_last;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.status   = status_r;
  assign out_ch.last     = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8_core.sv
// json_string_unescape_utf8_core: json string body unescaper to utf-8
// path: an accepted byte is queued as a command, then its first result goes to the output register
// throughput: one byte in and one result out per cycle unless stalled; a byte that expands
//   to up to four results holds the output longer; the queue absorbs the difference
// reset: synchronous active-low rst_n returns the parser to normal text, empties the queue
`default_nettype none

module json_string_unescape_utf8_core
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  // front: parses escapes and hex groups, one request accepted per cycle
  // while the queue has room; each byte queues at most one command
  logic     push_valid;
  jsu_cmd_t push_cmd;
  logic     q_full;

  // back: pops commands and sends 1 to 4 bytes each
  logic     head_valid;
  jsu_cmd_t head_cmd;
  logic     pop;

  jsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // decouples parser from encoder so each side stalls on its own
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // output register lives in the back, so results wait there without
  // blocking new input requests while the queue has room
  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/jsu_checker.sv
// jsu_checker: port-level assertions on the unescaper results
// depends on jsu_pkg; bound to json_string_unescape_utf8_core
`default_nettype none

module jsu_checker
  import jsu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_status,
  input wire logic       out_last
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // status results carry a zero byte
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_byte == 8'h00)
    else $error("nonzero byte on status result");

  // a status result is always the only result of its request
  a_stlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_BYTE |-> out_last)
    else $error("status result without last");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

`default_nettype wire

FILE: verif/json_string_unescape_utf8_core_tb.sv
`timescale 1ns / 1ps
// testbench of json_string_unescape_utf8_core: byte stream in, utf-8 bytes and status out
// depends on jsu_pkg, jsu_in_if / jsu_out_if and the core; predicts every result and
// compares in order while both sides idle and stall at random and the sink holds off

module json_string_unescape_utf8_core_tb;
  import jsu_pkg::*;

  // one decoded result as the output channel carries it
  typedef struct packed {
    logic [7:0]  data;
    jsu_status_t status;
    logic        last;
  } utf8_result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape_utf8_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoded bytes and statuses still to arrive, oldest first
  utf8_result_t decoded_q[$];

  int errors;
  int bytes_sent;
  bit src_idle_on;
  bit sink_idle_on;
  // the sink takes a new long hold-off whenever hold_seq moves
  int hold_seq;
  int hold_cycles;

  // decoder state of the predictor
  jsu_phase_t  esc_phase;
  logic [1:0]  digit_count;
  logic [15:0] first_unit;
  logic [15:0] second_unit;

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAIL json_string_unescape_utf8_core");
    $finish;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  task automatic push_decoded(input logic [7:0] b, input jsu_status_t st, input logic fin);
    utf8_result_t r;
    r.data   = b;
    r.status = st;
    r.last   = fin;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic restart_decoder();
    esc_phase   = PH_TEXT;
    digit_count = 2'd0;
    first_unit  = 16'h0000;
    second_unit = 16'h0000;
  endtask

  // any non-byte status is a single result and puts the decoder back to text
  task automatic fail_decoder(input jsu_status_t st);
    restart_decoder();
    push_decoded(8'h00, st, 1'b1);
  endtask

  // value of a hex digit, bit 4 set for anything else
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic encode_code_point(input logic [JSU_CP_W-1:0] cp);
    if (cp <= UTF8_MAX1) begin
      push_decoded(cp[7:0], ST_BYTE, 1'b1);
    end else if (cp <= UTF8_MAX2) begin
      push_decoded(8'hC0 | 8'(cp >> 6), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
    end else if (cp <= UTF8_MAX3) begin
      push_decoded(8'hE0 | 8'(cp >> 12), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[11:6]), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
    end else begin
      push_decoded(8'hF0 | 8'(cp[20:18]), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[17:12]), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[11:6]), ST_BYTE, 1'b0);
      push_decoded(8'h80 | 8'(cp[5:0]), ST_BYTE, 1'b1);
    end
  endtask

  // advance the decoder by one accepted byte, queueing what it produces
  task automatic decode_byte(input logic [7:0] c);
    logic [4:0]          h;
    logic [JSU_CP_W-1:0] cp;
    case (esc_phase)
      PH_ESC: begin
        esc_phase = PH_TEXT;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: push_decoded(c, ST_BYTE, 1'b1);
          CH_B: push_decoded(BYTE_BS, ST_BYTE, 1'b1);
          CH_F: push_decoded(BYTE_FF, ST_BYTE, 1'b1);
          CH_N: push_decoded(BYTE_LF, ST_BYTE, 1'b1);
          CH_R: push_decoded(BYTE_CR, ST_BYTE, 1'b1);
          CH_T: push_decoded(BYTE_TAB, ST_BYTE, 1'b1);
          CH_U: begin
            // start of a hex group, nothing comes out yet
            esc_phase   = PH_HEX_HI;
            digit_count = 2'd0;
            first_unit  = 16'h0000;
          end
          default: fail_decoder(ST_BADESC);
        endcase
      end
      PH_HEX_HI, PH_HEX_LO: begin
        h = digit_value(c);
        if (h[4]) begin
          fail_decoder(ST_BADHEX);
        end else begin
          if (esc_phase == PH_HEX_HI) first_unit = {first_unit[11:0], h[3:0]};
          else second_unit = {second_unit[11:0], h[3:0]};
          if (digit_count != 2'd3) begin
            digit_count = digit_count + 2'd1;
          end else begin
            digit_count = 2'd0;
            if (esc_phase == PH_HEX_HI && first_unit >= HI_SUR_MIN &&
                first_unit <= HI_SUR_MAX) begin
              // high surrogate, wait for the low half
              esc_phase = PH_WANT_BS;
            end else if (esc_phase == PH_HEX_LO &&
                         (second_unit < LO_SUR_MIN || second_unit > LO_SUR_MAX)) begin
              fail_decoder(ST_BADSUR);
            end else begin
              // a lone low surrogate lands here too and is encoded as given
              if (esc_phase == PH_HEX_HI) cp = JSU_CP_W'(first_unit);
              else cp = ((JSU_CP_W'(first_unit - HI_SUR_MIN) << 10) |
                         JSU_CP_W'(second_unit - LO_SUR_MIN)) + SUPP_BASE;
              esc_phase = PH_TEXT;
              encode_code_point(cp);
            end
          end
        end
      end
      PH_WANT_BS: begin
        if (c != CH_BSLASH) fail_decoder(ST_BADSUR);
        else esc_phase = PH_WANT_U;
      end
      PH_WANT_U: begin
        if (c != CH_U) begin
          fail_decoder(ST_BADSUR);
        end else begin
          esc_phase   = PH_HEX_LO;
          digit_count = 2'd0;
          second_unit = 16'h0000;
        end
      end
      default: begin
        // normal text
        esc_phase = PH_TEXT;
        if (c == CH_QUOTE) fail_decoder(ST_END);
        else if (c == CH_NUL) fail_decoder(ST_NOQUOTE);
        else if (c == CH_BSLASH) esc_phase = PH_ESC;
        else if (c < CTRL_LIMIT) fail_decoder(ST_CTRL);
        else push_decoded(c, ST_BYTE, 1'b1);
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------

  // offer one byte, optionally after an idle burst, and wait for the handshake;
  // valid stays high afterwards so back-to-back requests see no bubble
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  // four hex digits of a code unit, each in random case
  task automatic send_hex_digits(input logic [15:0] u);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(u[i*4 +: 4], 1'($urandom_range(0, 1))));
  endtask

  task automatic send_unit_escape(input logic [15:0] u);
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    send_hex_digits(u);
  endtask

  function automatic bit is_escape_letter(input logic [7:0] c);
    return c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U};
  endfunction

  // a token that the parser takes without error, or the closing quote; the last branch may also send a backslash
  task automatic send_good_token();
    int          sel;
    logic [7:0]  b;
    logic [15:0] u;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
      send_byte(b);
    end else if (sel < 55) begin
      send_byte(CH_BSLASH);
      case ($urandom_range(0, 7))
        0: send_byte(CH_QUOTE);
        1: send_byte(CH_BSLASH);
        2: send_byte(CH_SLASH);
        3: send_byte(CH_B);
        4: send_byte(CH_F);
        5: send_byte(CH_N);
        6: send_byte(CH_R);
        default: send_byte(CH_T);
      endcase
    end else if (sel < 75) begin
      // one unit, spread over the 1, 2 and 3 byte encodings and lone low halves
      case ($urandom_range(0, 4))
        0: u = 16'($urandom_range(16'h0000, 16'h007F));
        1: u = 16'($urandom_range(16'h0080, 16'h07FF));
        2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
        3: u = 16'($urandom_range(16'hE000, 16'hFFFF));
        default: u = 16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX));
      endcase
      send_unit_escape(u);
    end else if (sel < 88) begin
      // surrogate pair, four byte encoding
      send_unit_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
      send_unit_escape(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)));
    end else if (sel < 93) begin
      send_byte(CH_QUOTE);
    end else begin
      send_byte(8'($urandom_range(8'h20, 8'h7F)));
    end
  endtask

  // noise and broken sequences
  task automatic send_bad_token();
    logic [7:0]  b;
    logic [15:0] u;
    logic [4:0]  dv;
    int          n;
    case ($urandom_range(0, 3))
      0: send_byte(8'($urandom_range(0, 255)));
      1: begin
        // hex group cut short by a non-hex byte
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) send_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
        do begin
          b  = 8'($urandom_range(0, 255));
          dv = digit_value(b);
        end while (!dv[4]);
        send_byte(b);
      end
      2: begin
        // high surrogate without a proper low half
        send_unit_escape(16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX)));
        case ($urandom_range(0, 2))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
            send_byte(b);
          end
          1: begin
            send_byte(CH_BSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            send_byte(b);
          end
          default: begin
            do u = 16'($urandom_range(0, 16'hFFFF));
            while (u >= LO_SUR_MIN && u <= LO_SUR_MAX);
            send_unit_escape(u);
          end
        endcase
      end
      default: begin
        send_byte(CH_BSLASH);
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        send_byte(b);
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // result side: ready pattern, long hold-off and checking
  // ------------------------------------------------------------------

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_result();
    utf8_result_t want;
    if (decoded_q.size() == 0) begin
      note_error($sformatf("unexpected result: byte %02h status %0d last %0b",
                           out_ch.out_byte, out_ch.status, out_ch.last));
    end else begin
      want = decoded_q.pop_front();
      if (out_ch.out_byte !== want.data || out_ch.status !== want.status ||
          out_ch.last !== want.last)
        note_error($sformatf(
          "mismatch: expected byte %02h status %0d last %0b, got byte %02h status %0d last %0b",
          want.data, want.status, want.last, out_ch.out_byte, out_ch.status, out_ch.last));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left   = 0;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_cycles;
      end
      if (hold_left > 0) begin
        // long hold-off, the queue fills and the input stalls
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // field extremes and the corner cases of the parser
  task automatic test_directed_specials();
    send_byte(8'h20);        // lowest plain byte
    send_byte(8'hFF);        // highest plain byte
    send_byte(8'h1F);        // raw control byte
    send_byte(CH_QUOTE);     // closing quote
    send_byte(CH_NUL);       // end of text without closing quote
    send_text("\\q");        // unknown escape
    send_text("\\u0000");    // escaped zero comes out as a data byte
    send_text("\\uDC00");    // lone low surrogate, three bytes
    send_text("\\uD800");    // high surrogate cut off by end of text
    send_byte(CH_NUL);
  endtask

  // mostly well-formed text with random content, idling on both sides
  task automatic test_random_traffic(input int count);
    int target;
    target       = bytes_sent + count;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 99) < 80) send_good_token();
      else send_bad_token();
    end
  endtask

  // sink holds off while the source keeps offering, so the block backs up
  task automatic test_input_backpressure(input int count);
    int target;
    target       = bytes_sent + count;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_cycles  = 300;
    hold_seq++;
    while (bytes_sent < target) send_good_token();
  endtask

  // final stretch at full rate on both sides
  task automatic test_random_no_idle(input int count);
    int target;
    target       = bytes_sent + count;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 99) < 85) send_good_token();
      else send_bad_token();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    errors        = 0;
    bytes_sent    = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    hold_seq      = 0;
    hold_cycles   = 0;
    restart_decoder();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_specials();
    test_random_traffic(160);
    test_input_backpressure(50);
    test_random_no_idle(80);
    in_ch.valid <= 1'b0;

    // drain, then keep the clock running to catch stray results
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("PASS json_string_unescape_utf8_core");
    end else begin
      $display("FAIL json_string_unescape_utf8_core");
    end
    $finish;
  end

endmodule
